@@ rtl/tcbd_pkg.sv @@
package tcbd_pkg;

   localparam int IVL_BITS = 24;
   localparam logic [IVL_BITS-1:0] IVL_RESET = IVL_BITS'(1000);

   localparam int GAP_FIELD_W = 32;
   localparam int GAP_BITS = 32;
   localparam int MAX_ZERO_RUN = 63;

   localparam int BYTE_BITS = 8;
   localparam int CNT_W = $clog2(BYTE_BITS);

   localparam int REQ_DATA_W = ((GAP_FIELD_W + 1 + 7) / 8) * 8;
   localparam int RSP_USER_W = 2;

   localparam int QUOT_BITS = $clog2(MAX_ZERO_RUN + 1) + 1;
   localparam int STEP_W = (QUOT_BITS > 2) ? $clog2(QUOT_BITS) : 1;
   localparam int RUN_W = ($clog2(MAX_ZERO_RUN + 2) > 4) ? $clog2(MAX_ZERO_RUN + 2) : 4;
   localparam int CMP_W = (GAP_BITS + 1 > IVL_BITS + QUOT_BITS) ?
                          GAP_BITS + 1 : IVL_BITS + QUOT_BITS;

   localparam logic STREAM_OVERT = 1'b0;
   localparam logic STREAM_COVERT = 1'b1;

   typedef struct packed {
      logic                 run_clipped;
      logic                 stream;
   } rsp_user_type;

endpackage

@@ rtl/timing_channel_bit_decoder.sv @@
// Timing channel bit decoder.
//
// Each transfer on the req_ channel is one received packet: the gap in clock
// ticks measured before it and the overt bit it carries. Overt bits are
// assembled into bytes first bit most significant; covert bits are derived
// from the gap against the interval register and assembled the same way.
// Each completed byte leaves as one transfer on the rsp_ channel, covert
// bytes of an item first and its overt byte last, with rsp_tlast on the
// final transfer that the item causes.
// The csr_ port writes the interval register; the user is to write it only
// while the block is idle, which the block itself does not enforce.
// After acceptance an item passes the gap check, then, with covert data, the
// bit-serial divider that forms the quotient one bit at a time and the shift
// of up to 64 covert bits, and last the overt bit. req_tready is high only
// while idle, so no new item is accepted until the last one is through.
// A completed byte waits in the output register; when the receiver stalls,
// the shift of covert bits halts only at a bit that would complete a byte.
// Reset clears both byte assemblers, empties the output register and loads
// the interval register with 1000.
module timing_channel_bit_decoder import tcbd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [IVL_BITS-1:0]     csr_wr_data,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // gap_ticks, overt_bit
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [BYTE_BITS-1:0]    rsp_tdata,   // byte_value
   output logic [RSP_USER_W-1:0]   rsp_tuser,   // stream, run_clipped
   output logic                    rsp_tlast
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_EMIT  = 3'd3;
   localparam logic [2:0] ST_OVERT = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [IVL_BITS-1:0]     interval_ff, interval_in;
   logic [IVL_BITS-1:0]     ivl_ff, ivl_in;
   logic [GAP_BITS-1:0]     gap_ff, gap_in;
   logic                    obit_ff, obit_in;
   logic [CMP_W-1:0]        rem_ff, rem_in;
   logic [CMP_W-1:0]        dv_ff, dv_in;
   logic [QUOT_BITS-1:0]    quot_ff, quot_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [RUN_W-1:0]        remain_ff, remain_in;
   logic                    clip_ff, clip_in;
   logic [BYTE_BITS-2:0]    opart_ff, opart_in;
   logic [CNT_W-1:0]        ocnt_ff, ocnt_in;
   logic [BYTE_BITS-2:0]    cpart_ff, cpart_in;
   logic [CNT_W-1:0]        ccnt_ff, ccnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [BYTE_BITS-1:0]    rsp_byte_ff, rsp_byte_in;
   rsp_user_type            rsp_user_ff, rsp_user_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    slot_free;
   logic [GAP_BITS:0]       dbl_gap;
   logic                    has_covert;
   logic                    sub_ok;
   logic [QUOT_BITS-1:0]    quot_next;
   logic                    cbit;
   logic [BYTE_BITS-1:0]    cacc;
   logic [BYTE_BITS-1:0]    oacc;
   logic                    c_done;
   logic                    o_done;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign dbl_gap    = {gap_ff, 1'b0};
   assign has_covert = CMP_W'(dbl_gap) > CMP_W'(ivl_ff);
   assign sub_ok     = rem_ff >= dv_ff;
   assign quot_next  = {quot_ff[QUOT_BITS-2:0], sub_ok};
   assign cbit       = remain_ff == RUN_W'(1);
   assign cacc       = {cpart_ff, cbit};
   assign oacc       = {opart_ff, obit_ff};
   assign c_done     = ccnt_ff == CNT_W'(BYTE_BITS - 1);
   assign o_done     = ocnt_ff == CNT_W'(BYTE_BITS - 1);

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      interval_in  = interval_ff;
      ivl_in       = ivl_ff;
      gap_in       = gap_ff;
      obit_in      = obit_ff;
      rem_in       = rem_ff;
      dv_in        = dv_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      remain_in    = remain_ff;
      clip_in      = clip_ff;
      opart_in     = opart_ff;
      ocnt_in      = ocnt_ff;
      cpart_in     = cpart_ff;
      ccnt_in      = ccnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_wr_en) begin
         interval_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               gap_in   = req_tdata[GAP_BITS-1:0];
               obit_in  = req_tdata[GAP_FIELD_W];
               ivl_in   = (interval_ff == '0) ? IVL_BITS'(1) : interval_ff;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            clip_in = 1'b0;
            if (has_covert) begin
               rem_in   = CMP_W'(dbl_gap) - CMP_W'(ivl_ff);
               dv_in    = CMP_W'({ivl_ff, 1'b0, {(QUOT_BITS - 1){1'b0}}});
               quot_in  = '0;
               step_in  = STEP_W'(QUOT_BITS - 1);
               state_in = ST_DIV;
            end else begin
               state_in = ST_OVERT;
            end
         end
         ST_DIV: begin
            if (sub_ok) begin
               rem_in = rem_ff - dv_ff;
            end
            dv_in   = dv_ff >> 1;
            quot_in = quot_next;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               if (quot_next > QUOT_BITS'(MAX_ZERO_RUN)) begin
                  clip_in   = 1'b1;
                  remain_in = RUN_W'(MAX_ZERO_RUN + 1);
               end else begin
                  remain_in = RUN_W'(quot_next) + RUN_W'(1);
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!c_done || slot_free) begin
               if (c_done) begin
                  rsp_valid_in       = 1'b1;
                  rsp_byte_in        = cacc;
                  rsp_user_in.stream = STREAM_COVERT;
                  rsp_user_in.run_clipped = clip_ff;
                  rsp_last_in        = (remain_ff <= RUN_W'(BYTE_BITS)) && !o_done;
                  cpart_in           = '0;
                  ccnt_in            = '0;
               end else begin
                  cpart_in = cacc[BYTE_BITS-2:0];
                  ccnt_in  = ccnt_ff + CNT_W'(1);
               end
               remain_in = remain_ff - RUN_W'(1);
               if (cbit) begin
                  state_in = ST_OVERT;
               end
            end
         end
         ST_OVERT: begin
            if (!o_done || slot_free) begin
               if (o_done) begin
                  rsp_valid_in       = 1'b1;
                  rsp_byte_in        = oacc;
                  rsp_user_in.stream = STREAM_OVERT;
                  rsp_user_in.run_clipped = clip_ff;
                  rsp_last_in        = 1'b1;
                  opart_in           = '0;
                  ocnt_in            = '0;
               end else begin
                  opart_in = oacc[BYTE_BITS-2:0];
                  ocnt_in  = ocnt_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         interval_ff  <= IVL_RESET;
         opart_ff     <= '0;
         ocnt_ff      <= '0;
         cpart_ff     <= '0;
         ccnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         clip_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         opart_ff     <= opart_in;
         ocnt_ff      <= ocnt_in;
         cpart_ff     <= cpart_in;
         ccnt_ff      <= ccnt_in;
         rsp_valid_ff <= rsp_valid_in;
         clip_ff      <= clip_in;
      end
   end

   always_ff @(posedge clock) begin
      ivl_ff      <= ivl_in;
      gap_ff      <= gap_in;
      obit_ff     <= obit_in;
      rem_ff      <= rem_in;
      dv_ff       <= dv_in;
      quot_ff     <= quot_in;
      step_ff     <= step_in;
      remain_ff   <= remain_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   // The covert run counter never runs out while bits are still being shifted.
   a_emit_remain: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> remain_ff != '0)
      else $error("covert run counter empty during emission");

   // An accepted transfer always starts the gap check in the next cycle.
   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_PREP)
      else $error("accepted transfer did not start processing");

   // The divider leaves only toward emission, with a run of at most the maximum plus one.
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && step_ff == '0 |=>
         state_ff == ST_EMIT && remain_ff <= RUN_W'(MAX_ZERO_RUN + 1))
      else $error("divider exit out of range");

   // A new result is never loaded over one that the receiver has not taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready && (state_ff == ST_EMIT || state_ff == ST_OVERT) |=>
         $stable(rsp_byte_ff) && $stable(rsp_last_ff))
      else $error("pending result overwritten");

endmodule
